// ----- design/swls_pkg.sv -----
package swls_pkg;

	// window geometry
	localparam int WINDOW_DEPTH = 128;
	localparam int IDX_W = $clog2(WINDOW_DEPTH);
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int CMP_W = (FILL_W > 8) ? FILL_W : 8;

	// field widths
	localparam int SAMPLE_W = 32;
	localparam int SUM_W = 39;
	localparam int HIGH_W = 33;
	localparam int WEIGHT_W = 17;
	localparam int SPAN_W = 31;
	localparam int CFG_IDX_W = 2;

	// empty window gives a range of 1.0
	localparam logic signed [HIGH_W-1:0] EMPTY_HIGH = 33'sd65536;

	// register reset values
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd655;
	localparam logic [SPAN_W-1:0] SPAN_RESET = 31'd6554;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EMA_WEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN = 2'd1;

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_READ = 2'd1,
		CMD_RANGE = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_LAP,
		ST_FIN,
		ST_DONE
	} state_t;

endpackage

// ----- design/swls_cell.sv -----
module swls_cell (
	input  logic                                 clk,
	input  logic                                 shift,
	input  logic signed [swls_pkg::SAMPLE_W-1:0] d,
	output logic signed [swls_pkg::SAMPLE_W-1:0] q
);

	logic signed [swls_pkg::SAMPLE_W-1:0] value_q;

	// take the neighbour's entry when the row moves
	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= d;
		end
	end

	assign q = value_q;

endmodule

// ----- design/swls_ema.sv -----
module swls_ema (
	input  logic                                 clk,
	input  logic signed [swls_pkg::SAMPLE_W-1:0] sample,
	input  logic signed [swls_pkg::SAMPLE_W-1:0] ema,
	input  logic        [swls_pkg::WEIGHT_W-1:0] weight,
	output logic signed [swls_pkg::SAMPLE_W-1:0] next_ema
);

	logic signed [32:0] diff;
	logic signed [50:0] prod_d;
	logic signed [50:0] prod_s1;
	logic signed [34:0] delta;
	logic signed [34:0] sum;

	// difference times weight, registered
	assign diff = 33'(sample) - 33'(ema);
	assign prod_d = 51'(diff) * 51'($signed({1'b0, weight}));

	always_ff @(posedge clk) begin
		prod_s1 <= prod_d;
	end

	// arithmetic shift floors the scaled step
	assign delta = 35'(prod_s1 >>> 16);
	assign sum = 35'(ema) + delta;

	// clamp to the signed 32-bit range
	always_comb begin
		if (sum > 35'sd2147483647) begin
			next_ema = 32'sh7FFFFFFF;
		end else if (sum < -35'sd2147483648) begin
			next_ema = 32'sh80000000;
		end else begin
			next_ema = 32'(sum);
		end
	end

endmodule

// ----- design/sliding_window_loss_statistics.sv -----
// Sliding window statistics over signed Q16.16 samples.
// Items enter on start while busy is low: command, sample_value, entry_index.
// Each item yields exactly one result, shown for one cycle with done high;
// the receiver cannot stall, so a result must be taken in that cycle.
// The window is a row of cells that shift on a push; the newest entry sits
// in the first cell and the entry evicted from a full window leaves the last.
// A push updates the window as it is accepted, then runs the EMA multiply
// and the clamped add. A read or a range query turns the whole row once as
// a ring, one cell a cycle, watching the last cell. A read beyond the fill
// count, a range on an empty window and the unused command finish without
// turning the row. A new item may be given in the cycle that done is high.
// The user writes registers through cfg_write/cfg_index/cfg_data only while
// idle; the block itself does not enforce this. Reset empties the window,
// clears sum and EMA and restores the register defaults; cell contents stay
// undefined and are never read before written.
module sliding_window_loss_statistics (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic        [swls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [swls_pkg::SPAN_W-1:0]    cfg_data,
	input  logic                                  start,
	output logic                                  busy,
	input  logic        [1:0]                     command,
	input  logic signed [swls_pkg::SAMPLE_W-1:0]  sample_value,
	input  logic        [7:0]                     entry_index,
	output logic                                  done,
	output logic signed [swls_pkg::SAMPLE_W-1:0]  entry_value,
	output logic signed [swls_pkg::SAMPLE_W-1:0]  range_low,
	output logic signed [swls_pkg::HIGH_W-1:0]    range_high,
	output logic signed [swls_pkg::SUM_W-1:0]     window_sum,
	output logic signed [swls_pkg::SAMPLE_W-1:0]  smoothed_value,
	output logic        [7:0]                     fill_count
);

	localparam int D = swls_pkg::WINDOW_DEPTH;

	swls_pkg::state_t state_q, state_d;
	swls_pkg::cmd_t cmd_in, cmd_q;

	logic accept;
	logic push_now;
	logic shift;
	logic full;
	logic tap_valid;
	logic idx_hit;

	logic [swls_pkg::WEIGHT_W-1:0] ema_weight_q;
	logic [swls_pkg::SPAN_W-1:0] min_span_q;
	logic [swls_pkg::FILL_W-1:0] fill_q;
	logic signed [swls_pkg::SUM_W-1:0] sum_q;
	logic signed [swls_pkg::SAMPLE_W-1:0] ema_q;
	logic signed [swls_pkg::SAMPLE_W-1:0] next_ema;
	logic [swls_pkg::IDX_W-1:0] lap_q;
	logic seen_q;
	logic first_q;

	logic signed [swls_pkg::SAMPLE_W-1:0] sample_q;
	logic [swls_pkg::FILL_W-1:0] start_pos_q;
	logic [swls_pkg::IDX_W-1:0] target_q;
	logic signed [swls_pkg::SAMPLE_W-1:0] entry_q;
	logic signed [swls_pkg::SAMPLE_W-1:0] lo_q;
	logic signed [swls_pkg::HIGH_W-1:0] hi_q;

	logic [swls_pkg::FILL_W-1:0] start_pos_d;
	logic [swls_pkg::CMP_W:0] target_d;
	logic signed [swls_pkg::SAMPLE_W-1:0] tap;
	logic signed [swls_pkg::SAMPLE_W-1:0] chain [D+1];
	logic signed [33:0] spread;
	logic signed [33:0] span_ext;

	assign cmd_in = swls_pkg::cmd_t'(command);
	assign accept = start && !busy;
	assign push_now = accept && (cmd_in == swls_pkg::CMD_PUSH);
	assign shift = push_now || (state_q == swls_pkg::ST_LAP);
	assign full = (fill_q == swls_pkg::FILL_W'(D));

	// row of window cells, closed into a ring while it is walked
	assign chain[0] = push_now ? sample_value : tap;
	assign tap = chain[D];

	for (genvar i = 0; i < D; i++) begin : g_cell
		swls_cell u_cell (
			.clk  (clk),
			.shift(shift),
			.d    (chain[i]),
			.q    (chain[i+1])
		);
	end

	// ema step unit
	swls_ema u_ema (
		.clk     (clk),
		.sample  (sample_q),
		.ema     (ema_q),
		.weight  (ema_weight_q),
		.next_ema(next_ema)
	);

	// position of the oldest entry as seen at the tap, and the read target
	assign start_pos_d = swls_pkg::FILL_W'(D) - fill_q;
	assign target_d = (swls_pkg::CMP_W+1)'(start_pos_d) + (swls_pkg::CMP_W+1)'(entry_index);
	assign idx_hit = swls_pkg::CMP_W'(entry_index) < swls_pkg::CMP_W'(fill_q);
	assign tap_valid = swls_pkg::FILL_W'(lap_q) >= start_pos_q;

	assign spread = 34'(hi_q) - 34'(lo_q);
	assign span_ext = 34'($signed({1'b0, min_span_q}));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swls_pkg::ST_IDLE, swls_pkg::ST_DONE: begin
				if (accept) begin
					unique case (cmd_in)
						swls_pkg::CMD_PUSH: state_d = swls_pkg::ST_MUL;
						swls_pkg::CMD_READ: state_d = idx_hit ? swls_pkg::ST_LAP : swls_pkg::ST_DONE;
						swls_pkg::CMD_RANGE: begin
							state_d = (fill_q == '0) ? swls_pkg::ST_DONE : swls_pkg::ST_LAP;
						end
						swls_pkg::CMD_NONE: state_d = swls_pkg::ST_DONE;
					endcase
				end else begin
					state_d = swls_pkg::ST_IDLE;
				end
			end
			swls_pkg::ST_MUL: state_d = swls_pkg::ST_ADD;
			swls_pkg::ST_ADD: state_d = swls_pkg::ST_DONE;
			swls_pkg::ST_LAP: begin
				if (lap_q == swls_pkg::IDX_W'(D - 1)) begin
					state_d = swls_pkg::ST_FIN;
				end
			end
			swls_pkg::ST_FIN: state_d = swls_pkg::ST_DONE;
			default: state_d = swls_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			swls_pkg::ST_IDLE: busy = 1'b0;
			swls_pkg::ST_DONE: begin
				busy = 1'b0;
				done = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

	// control state, window bookkeeping and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swls_pkg::ST_IDLE;
			cmd_q <= swls_pkg::CMD_NONE;
			ema_weight_q <= swls_pkg::WEIGHT_RESET;
			min_span_q <= swls_pkg::SPAN_RESET;
			fill_q <= '0;
			sum_q <= '0;
			ema_q <= '0;
			lap_q <= '0;
			seen_q <= 1'b0;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				if (cfg_index == swls_pkg::REG_EMA_WEIGHT) begin
					ema_weight_q <= cfg_data[swls_pkg::WEIGHT_W-1:0];
				end else if (cfg_index == swls_pkg::REG_MIN_SPAN) begin
					min_span_q <= cfg_data;
				end
			end
			if (accept) begin
				cmd_q <= cmd_in;
				lap_q <= '0;
				seen_q <= 1'b0;
			end
			if (push_now) begin
				first_q <= (fill_q == '0);
				sum_q <= sum_q + 39'(sample_value) - (full ? 39'(tap) : '0);
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (state_q == swls_pkg::ST_ADD) begin
				ema_q <= first_q ? sample_q : next_ema;
			end
			if (state_q == swls_pkg::ST_LAP) begin
				lap_q <= lap_q + 1'b1;
				if (tap_valid) begin
					seen_q <= 1'b1;
				end
			end
		end
	end

	// item payload and result values
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_value;
			start_pos_q <= start_pos_d;
			target_q <= target_d[swls_pkg::IDX_W-1:0];
			entry_q <= '0;
			lo_q <= '0;
			hi_q <= (cmd_in == swls_pkg::CMD_RANGE && fill_q == '0) ? swls_pkg::EMPTY_HIGH : '0;
		end
		if (state_q == swls_pkg::ST_LAP) begin
			if (cmd_q == swls_pkg::CMD_READ) begin
				if (lap_q == target_q) begin
					entry_q <= tap;
				end
			end else if (tap_valid) begin
				if (!seen_q || tap < lo_q) begin
					lo_q <= tap;
				end
				if (!seen_q || 33'(tap) > hi_q) begin
					hi_q <= 33'(tap);
				end
			end
		end
		// widen a narrow range to the minimum span
		if (state_q == swls_pkg::ST_FIN && cmd_q == swls_pkg::CMD_RANGE) begin
			if (spread < span_ext) begin
				hi_q <= 33'(34'(lo_q) + span_ext);
			end
		end
	end

	assign entry_value = entry_q;
	assign range_low = lo_q;
	assign range_high = hi_q;
	assign window_sum = sum_q;
	assign smoothed_value = ema_q;
	assign fill_count = 8'(fill_q);

endmodule

// ----- design/swls_checker.sv -----
module swls_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 done,
	input logic signed [swls_pkg::SUM_W-1:0]    window_sum,
	input logic        [7:0]                    fill_count
);

	// a result never shows while the block is working
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// an accepted item leaves the block busy or finished
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item lost");

	// a result follows work or an accepted item
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start && !busy)))
		else $error("result without an item");

	// an empty window sums to zero
	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(done && fill_count == 8'd0) |-> (window_sum == '0))
		else $error("empty window with non-zero sum");

endmodule

bind sliding_window_loss_statistics swls_checker u_swls_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.window_sum(window_sum),
	.fill_count(fill_count)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

	import swls_pkg::*;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
	localparam int unsigned WEIGHT_ALL = 131071;
	localparam int unsigned SPAN_MAX = 32'h7FFF_FFFF;
	localparam int QUIET_LIMIT = 2000;

	typedef struct {
		logic signed [SAMPLE_W-1:0] entry;
		logic signed [SAMPLE_W-1:0] low;
		logic signed [HIGH_W-1:0]   high;
		logic signed [SUM_W-1:0]    sum;
		logic signed [SAMPLE_W-1:0] ema;
		logic        [7:0]          fill;
	} stats_result_t;

	// window statistics tracker: own copy of the window, sum, ema and registers
	class window_stats_tracker;
		int          cells [WINDOW_DEPTH];
		int unsigned wr_pos;
		int unsigned filled;
		longint      total;
		int          ema;
		int unsigned weight;
		int unsigned span;
		int          errors;
		stats_result_t awaited [$];

		function new();
			wr_pos = 0;
			filled = 0;
			total = 0;
			ema = 0;
			weight = WEIGHT_RESET;
			span = SPAN_RESET;
			errors = 0;
		endfunction

		function void set_config(int unsigned new_weight, int unsigned new_span);
			weight = new_weight & WEIGHT_ALL;
			span = new_span & SPAN_MAX;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function int cell_at_age(int unsigned age);
			return cells[(wr_pos + WINDOW_DEPTH - filled + age) % WINDOW_DEPTH];
		endfunction

		// work out the result of one accepted item and queue it
		function void take_item(cmd_t cmd, logic signed [SAMPLE_W-1:0] s, logic [7:0] idx);
			stats_result_t r;
			longint lo;
			longint hi;
			longint v;
			longint nxt;
			lo = 0;
			hi = 0;
			r.entry = '0;
			case (cmd)
				CMD_PUSH: begin
					if (filled == WINDOW_DEPTH)
						total -= longint'(cells[wr_pos]);
					cells[wr_pos] = s;
					total += longint'(s);
					wr_pos = (wr_pos + 1) % WINDOW_DEPTH;
					if (filled < WINDOW_DEPTH)
						filled++;
					if (filled == 1) begin
						ema = s;
					end else begin
						// floor of the weighted difference, then clamp
						nxt = longint'(ema)
							+ (((longint'(s) - longint'(ema)) * longint'(weight)) >>> 16);
						if (nxt > longint'(SAMPLE_MAX))
							nxt = longint'(SAMPLE_MAX);
						if (nxt < longint'(SAMPLE_MIN))
							nxt = longint'(SAMPLE_MIN);
						ema = int'(nxt);
					end
				end
				CMD_READ: begin
					if (idx < filled)
						r.entry = cell_at_age(idx);
				end
				CMD_RANGE: begin
					if (filled == 0) begin
						hi = longint'(EMPTY_HIGH);
					end else begin
						lo = cell_at_age(0);
						hi = lo;
						for (int unsigned i = 1; i < filled; i++) begin
							v = cell_at_age(i);
							if (v < lo)
								lo = v;
							if (v > hi)
								hi = v;
						end
						// widen to the smallest reported span
						if (hi - lo < longint'(span))
							hi = lo + longint'(span);
					end
				end
				default: begin
				end
			endcase
			r.low = SAMPLE_W'(lo);
			r.high = HIGH_W'(hi);
			r.sum = SUM_W'(total);
			r.ema = ema;
			r.fill = 8'(filled);
			awaited.push_back(r);
		endfunction

		function void compare(string name, logic signed [63:0] want, logic signed [63:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		// compare one result with the oldest expectation
		function void check_result(logic signed [SAMPLE_W-1:0] entry,
				logic signed [SAMPLE_W-1:0] low, logic signed [HIGH_W-1:0] high,
				logic signed [SUM_W-1:0] sum, logic signed [SAMPLE_W-1:0] ema_out,
				logic [7:0] fill);
			stats_result_t r;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, expected none, actual sum %0d",
					$time, sum);
				return;
			end
			r = awaited.pop_front();
			compare("entry_value", r.entry, entry);
			compare("range_low", r.low, low);
			compare("range_high", r.high, high);
			compare("window_sum", r.sum, sum);
			compare("smoothed_value", r.ema, ema_out);
			compare("fill_count", r.fill, fill);
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_write;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [SPAN_W-1:0]           cfg_data;
	logic                        start;
	logic                        busy;
	logic [1:0]                  command;
	logic signed [SAMPLE_W-1:0]  sample_value;
	logic [7:0]                  entry_index;
	logic                        done;
	logic signed [SAMPLE_W-1:0]  entry_value;
	logic signed [SAMPLE_W-1:0]  range_low;
	logic signed [HIGH_W-1:0]    range_high;
	logic signed [SUM_W-1:0]     window_sum;
	logic signed [SAMPLE_W-1:0]  smoothed_value;
	logic [7:0]                  fill_count;

	window_stats_tracker tracker = new();
	int quiet_cycles;

	sliding_window_loss_statistics DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.sample_value   (sample_value),
		.entry_index    (entry_index),
		.done           (done),
		.entry_value    (entry_value),
		.range_low      (range_low),
		.range_high     (range_high),
		.window_sum     (window_sum),
		.smoothed_value (smoothed_value),
		.fill_count     (fill_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			tracker.check_result(entry_value, range_low, range_high, window_sum,
				smoothed_value, fill_count);
	end

	// watchdog on cycles with no item or result moving
	always @(posedge clk) begin
		if (!arst_n || (start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// present one item, with random idle cycles first, and wait for it to be taken
	task automatic send_item(cmd_t cmd, logic signed [SAMPLE_W-1:0] s, logic [7:0] idx,
			int unsigned idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		command <= cmd;
		sample_value <= s;
		entry_index <= idx;
		start <= 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		tracker.take_item(cmd, s, idx);
	endtask

	// drop start and wait until every result is in and the block is idle
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0 || busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic write_regs(int unsigned weight, int unsigned span);
		cfg_write <= 1'b1;
		cfg_index <= REG_EMA_WEIGHT;
		cfg_data <= SPAN_W'(weight);
		@(posedge clk);
		cfg_index <= REG_MIN_SPAN;
		cfg_data <= SPAN_W'(span);
		@(posedge clk);
		cfg_write <= 1'b0;
		tracker.set_config(weight, span);
	endtask

	function automatic cmd_t pick_command();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 58)
			return CMD_PUSH;
		if (r < 83)
			return CMD_READ;
		if (r < 95)
			return CMD_RANGE;
		return CMD_NONE;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return SAMPLE_W'($urandom_range(0, 2000)) - 1000;
			3: return '0;
			4: return SAMPLE_W'($urandom_range(0, 65535)) <<< $urandom_range(0, 16);
			default: return $urandom;
		endcase
	endfunction

	// mostly valid ages or one past the end, sometimes anything
	function automatic logic [7:0] pick_index();
		if ($urandom_range(0, 9) < 7)
			return 8'($urandom_range(0, tracker.filled));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic random_phase(int n_items, int unsigned idle_pct);
		for (int k = 0; k < n_items; k++)
			send_item(pick_command(), pick_sample(), pick_index(), idle_pct);
	endtask

	// fill the whole window with one value, then ask for the range and read the newest entry
	task automatic push_run(logic signed [SAMPLE_W-1:0] s, int unsigned idle_pct);
		for (int k = 0; k < WINDOW_DEPTH + 2; k++)
			send_item(CMD_PUSH, s, 8'($urandom), idle_pct);
		send_item(CMD_RANGE, $urandom, 8'($urandom), idle_pct);
		send_item(CMD_READ, $urandom, 8'(WINDOW_DEPTH - 1), idle_pct);
	endtask

	// stimulus
	initial begin
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		start <= 1'b0;
		command <= CMD_PUSH;
		sample_value <= '0;
		entry_index <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// empty window, unused command, first push, extremes, reads in and out of range
		send_item(CMD_RANGE, '0, 8'd0, 0);
		send_item(CMD_READ, '0, 8'd0, 0);
		send_item(CMD_NONE, $urandom, 8'd255, 0);
		send_item(CMD_PUSH, SAMPLE_MAX, 8'd0, 0);
		send_item(CMD_READ, '0, 8'd0, 0);
		send_item(CMD_PUSH, SAMPLE_MIN, 8'd0, 0);
		send_item(CMD_PUSH, '0, 8'd0, 0);
		send_item(CMD_PUSH, -32'sd1, 8'd0, 0);
		send_item(CMD_READ, '0, 8'd3, 0);
		send_item(CMD_READ, '0, 8'd4, 0);
		send_item(CMD_READ, '0, 8'd255, 0);
		send_item(CMD_RANGE, '0, 8'd0, 0);

		// weight of one, no widening
		settle();
		write_regs(65536, 0);
		send_item(CMD_PUSH, 32'sd12345, 8'd0, 0);
		send_item(CMD_PUSH, -32'sd5, 8'd0, 0);
		send_item(CMD_RANGE, '0, 8'd0, 0);

		// weight above one: ema clamps at both ends; widest span
		settle();
		write_regs(WEIGHT_ALL, SPAN_MAX);
		send_item(CMD_PUSH, SAMPLE_MIN, 8'd0, 0);
		send_item(CMD_PUSH, SAMPLE_MAX, 8'd0, 0);
		send_item(CMD_PUSH, SAMPLE_MIN, 8'd0, 0);
		send_item(CMD_RANGE, '0, 8'd0, 0);

		// zero weight freezes the ema
		settle();
		write_regs(0, SPAN_RESET);
		send_item(CMD_PUSH, 32'sd777, 8'd0, 0);
		send_item(CMD_NONE, $urandom, 8'd0, 0);
		send_item(CMD_RANGE, '0, 8'd0, 0);

		// sender idles now and then
		settle();
		write_regs($urandom_range(0, 65536), SPAN_MAX);
		push_run(SAMPLE_MAX, 13);
		random_phase(340, 13);

		// sender idles most of the time
		settle();
		write_regs(65536, 0);
		push_run(SAMPLE_MIN, 72);
		random_phase(340, 72);

		// back to back items
		settle();
		write_regs($urandom_range(0, WEIGHT_ALL), $urandom_range(0, 1 << 20));
		random_phase(470, 0);

		settle();
		repeat (WINDOW_DEPTH + 8) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
design/swls_pkg.sv
design/swls_cell.sv
design/swls_ema.sv
design/sliding_window_loss_statistics.sv
design/swls_checker.sv
tb/tb.sv
